@@ rtl/sine_cosine_poly_unit_assert.svh @@
// Assertion macros shared by the RTL.
// Each macro clocks on clk and is silent while rst_n is low.
`ifndef SINE_COSINE_POLY_UNIT_ASSERT_SVH
`define SINE_COSINE_POLY_UNIT_ASSERT_SVH

// Check cond at every edge.
`define SCP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check cons in the same cycle whenever ante holds.
`define SCP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante holds.
`define SCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/scp_pkg.sv @@
`timescale 1ns / 1ps

package scp_pkg;

    typedef logic signed [31:0] t_angle;
    typedef logic signed [31:0] t_q230;

    // Coefficient set selection
    localparam int unsigned POLY_LEVEL_DEF = 5;
    localparam int unsigned POLY_LEVEL_MIN = 3;
    localparam int unsigned POLY_LEVEL_MAX = 5;
    localparam int unsigned NCOEF          = 5;

    // 2/pi as an unsigned fraction of 2^32
    localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;

    // 1.0 in Q2.30
    localparam t_q230 Q_ONE = 32'sh4000_0000;

    // Q2.30 coefficients, highest power first, rows for levels 3, 4 and 5
    localparam logic signed [31:0] COEF_TAB [3][NCOEF] = '{
        '{32'sd0,      32'sd0,        32'sd76720259, -32'sd689007067, 32'sd1686028632},
        '{32'sd0,      -32'sd4640914, 32'sd85274018, -32'sd693514494, 32'sd1686623215},
        '{32'sd161727, -32'sd5016330, 32'sd85564564, -32'sd693597806, 32'sd1686629669}
    };

    // Coefficient k (0 = highest power) of the level lvl set, which has lvl terms
    function automatic logic signed [31:0] coef(input int unsigned lvl, input int unsigned k);
        return COEF_TAB[2'(lvl - POLY_LEVEL_MIN)][3'(NCOEF - lvl + k)];
    endfunction

endpackage

@@ rtl/scp_in_if.sv @@
`timescale 1ns / 1ps

interface scp_in_if;
    logic            valid;
    logic            ready;
    scp_pkg::t_angle angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

@@ rtl/scp_out_if.sv @@
`timescale 1ns / 1ps

interface scp_out_if;
    logic           valid;
    logic           ready;
    scp_pkg::t_q230 sine;
    scp_pkg::t_q230 cosine;

    modport source (output valid, output sine, output cosine, input ready);
    modport sink   (input valid, input sine, input cosine, output ready);
endinterface

@@ rtl/sine_cosine_poly_unit.sv @@
`timescale 1ns / 1ps
// Fixed-point sine and cosine of one angle per word.
//
// Input channel i_in: valid/ready word with angle in radians, signed Q8.24.
// Output channel o_out: valid/ready word with sine and cosine, signed Q2.30,
// saturated to +-1.0. A word moves on a rising edge with valid and ready high.
//
// Pipeline: multiply by 2/pi, round to quarter-turns, fold into a triangle
// wave, square, then one stage per Horner step and a final multiply and
// saturate. Throughput is one word per cycle while o_out.ready stays high;
// sine and cosine run in parallel lanes.
//
// Every stage carries a valid bit. A stage loads when it is empty or when
// the stage after it moves, so bubbles collapse while the receiver stalls and
// i_in.ready drops only once every stage holds a word. A stalled result holds
// at the output register; nothing is dropped or repeated.
//
// Reset (synchronous, active low) clears the valid bits only; data registers
// keep whatever they held and are ignored until refilled.
`include "sine_cosine_poly_unit_assert.svh"

module sine_cosine_poly_unit #(
    parameter int unsigned POLY_LEVEL = scp_pkg::POLY_LEVEL_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scp_in_if.sink    i_in,
    scp_out_if.source o_out
);

    // Clamp the level into the supported range
    localparam int unsigned LVL = (POLY_LEVEL < scp_pkg::POLY_LEVEL_MIN) ? scp_pkg::POLY_LEVEL_MIN :
                                  (POLY_LEVEL > scp_pkg::POLY_LEVEL_MAX) ? scp_pkg::POLY_LEVEL_MAX :
                                  POLY_LEVEL;
    // Horner product stages: one per multiply by x^2
    localparam int unsigned NH     = LVL - 1;
    localparam int unsigned ST_H0  = 4;
    localparam int unsigned ST_Y   = ST_H0 + NH;
    localparam int unsigned ST_OUT = ST_Y + 1;
    localparam int unsigned NSTG   = ST_OUT + 1;

    localparam logic signed [39:0] Q_ONE40 = 40'sh00_4000_0000;
    localparam logic signed [33:0] Q_ONE34 = 34'sh0_4000_0000;
    localparam logic signed [34:0] Q_ONE35 = 35'sh0_4000_0000;

    // Round a Q.60 product back to Q.30, ties toward plus infinity
    function automatic logic signed [34:0] rnd30(input logic signed [64:0] v);
        logic signed [64:0] s;
        s = v + (65'sd1 <<< 29);
        return s[64:30];
    endfunction

    // Fold quarter-turns u (Q.30) into a triangle wave on [-1, 1], Q2.30
    function automatic logic signed [31:0] fold(input logic signed [39:0] u);
        logic signed [9:0]  fl;
        logic signed [9:0]  qi;
        logic signed [9:0]  od;
        logic signed [39:0] d;
        logic signed [32:0] d33;
        logic signed [32:0] mag;
        logic signed [33:0] ext;
        logic signed [33:0] f;
        fl  = u[39:30];
        // truncate toward zero: floor, plus one for negative values with a fraction
        qi  = (u[39] && (u[29:0] != 30'd0)) ? fl + 10'sd1 : fl;
        od  = qi | 10'sd1;
        d   = u - $signed({od, 30'd0});
        d33 = d[32:0];
        mag = d33[32] ? -d33 : d33;
        ext = {mag[32], mag};
        f   = qi[1] ? (ext - Q_ONE34) : (Q_ONE34 - ext);
        return f[31:0];
    endfunction

    // Stage handshake: valid bits and load enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_en;

    assign w_en[ST_OUT]  = !r_vld[ST_OUT] || o_out.ready;
    assign n_vld[0]      = w_en[0] ? i_in.valid : r_vld[0];

    genvar s;
    generate
        for (s = 0; s < ST_OUT; s++) begin : g_en
            assign w_en[s]    = !r_vld[s] || w_en[s+1];
            assign n_vld[s+1] = w_en[s+1] ? r_vld[s] : r_vld[s+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_in.ready = w_en[0];
    assign o_out.valid = r_vld[ST_OUT];

    // Stage 0: angle times 2/pi, Q8.24 x Q0.32 = Q.56
    logic signed [63:0] r_prod;
    logic signed [64:0] w_prod;

    assign w_prod = $signed(i_in.angle) * $signed({1'b0, scp_pkg::TWO_OVER_PI_Q32});

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_prod <= w_prod[63:0];
        end
    end

    // Stage 1: round to Q.30 quarter-turns; cosine lane adds one quarter-turn
    logic signed [39:0] r_u [2];
    logic signed [63:0] w_prod_rnd;
    logic signed [39:0] w_u;

    assign w_prod_rnd = r_prod + (64'sd1 <<< 25);
    assign w_u        = {{2{w_prod_rnd[63]}}, w_prod_rnd[63:26]};

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_u[0] <= w_u;
            r_u[1] <= w_u + Q_ONE40;
        end
    end

    // Per-lane datapath, lane 0 sine and lane 1 cosine
    logic signed [31:0] r_f2  [2];
    logic signed [63:0] r_sq  [2];
    logic signed [31:0] r_f3  [2];
    logic signed [31:0] r_hx2 [2][NH];
    logic signed [64:0] r_hp  [2][NH];
    logic signed [31:0] r_hf  [2][NH];
    logic signed [64:0] r_pf  [2];
    logic signed [31:0] r_res [2];

    genvar p, j;
    generate
        for (p = 0; p < 2; p++) begin : g_lane
            // Stage 2: fold
            always_ff @(posedge i_clk) begin
                if (w_en[2]) begin
                    r_f2[p] <= fold(r_u[p]);
                end
            end

            // Stage 3: square the folded value
            always_ff @(posedge i_clk) begin
                if (w_en[3]) begin
                    r_sq[p] <= r_f2[p] * r_f2[p];
                    r_f3[p] <= r_f2[p];
                end
            end

            // Horner stages: add the next coefficient, multiply by x^2
            for (j = 0; j < NH; j++) begin : g_horner
                logic signed [31:0] w_x2;
                logic signed [32:0] w_y;
                logic signed [31:0] w_f;
                logic signed [34:0] w_acc;
                logic signed [31:0] w_c;

                assign w_c = scp_pkg::coef(LVL, j);

                if (j == 0) begin : g_first
                    logic signed [34:0] w_sq_rnd;
                    assign w_sq_rnd = rnd30({r_sq[p][63], r_sq[p]});
                    assign w_x2     = w_sq_rnd[31:0];
                    assign w_acc    = {{3{w_c[31]}}, w_c};
                    assign w_f      = r_f3[p];
                end else begin : g_next
                    assign w_x2  = r_hx2[p][j-1];
                    assign w_acc = {{3{w_c[31]}}, w_c} + rnd30(r_hp[p][j-1]);
                    assign w_f   = r_hf[p][j-1];
                end

                assign w_y = w_acc[32:0];

                always_ff @(posedge i_clk) begin
                    if (w_en[ST_H0 + j]) begin
                        r_hx2[p][j] <= w_x2;
                        r_hp[p][j]  <= w_y * w_x2;
                        r_hf[p][j]  <= w_f;
                    end
                end
            end

            // Last coefficient, then multiply by the folded value
            logic signed [31:0] w_cl;
            logic signed [34:0] w_accl;
            logic signed [32:0] w_yl;

            assign w_cl   = scp_pkg::coef(LVL, NH);
            assign w_accl = {{3{w_cl[31]}}, w_cl} + rnd30(r_hp[p][NH-1]);
            assign w_yl   = w_accl[32:0];

            always_ff @(posedge i_clk) begin
                if (w_en[ST_Y]) begin
                    r_pf[p] <= r_hf[p][NH-1] * w_yl;
                end
            end

            // Output stage: round and saturate to +-1.0
            logic signed [34:0] w_r;

            assign w_r = rnd30(r_pf[p]);

            always_ff @(posedge i_clk) begin
                if (w_en[ST_OUT]) begin
                    if (w_r > Q_ONE35) begin
                        r_res[p] <= scp_pkg::Q_ONE;
                    end else if (w_r < -Q_ONE35) begin
                        r_res[p] <= -scp_pkg::Q_ONE;
                    end else begin
                        r_res[p] <= w_r[31:0];
                    end
                end
            end
        end
    endgenerate

    assign o_out.sine   = r_res[0];
    assign o_out.cosine = r_res[1];

    // Checks
    `SCP_ASSERT_SAME(a_out_range, i_clk, i_rst_n, o_out.valid, (o_out.sine <= scp_pkg::Q_ONE) && (o_out.sine >= -scp_pkg::Q_ONE) && (o_out.cosine <= scp_pkg::Q_ONE) && (o_out.cosine >= -scp_pkg::Q_ONE), "result beyond +-1.0")
    `SCP_ASSERT_SAME(a_fold_range, i_clk, i_rst_n, r_vld[2], (r_f2[0] <= scp_pkg::Q_ONE) && (r_f2[0] >= -scp_pkg::Q_ONE) && (r_f2[1] <= scp_pkg::Q_ONE) && (r_f2[1] >= -scp_pkg::Q_ONE), "folded value outside [-1, 1]")
    `SCP_ASSERT_SAME(a_x2_range, i_clk, i_rst_n, r_vld[ST_H0], (r_hx2[0][0] >= 32'sd0) && (r_hx2[0][0] <= scp_pkg::Q_ONE) && (r_hx2[1][0] >= 32'sd0) && (r_hx2[1][0] <= scp_pkg::Q_ONE), "square outside [0, 1]")
    `SCP_ASSERT_NEXT(a_stage0_hold, i_clk, i_rst_n, r_vld[0] && !w_en[1], r_vld[0] && $stable(r_prod), "stalled first stage lost its word")
    `SCP_ASSERT_ALWAYS(a_ready_when_drained, i_clk, i_rst_n, r_vld[ST_OUT] || i_in.ready, "input stalled with an empty output stage")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

// Check the sine/cosine unit word by word against a predictor of its own.
// One angle word in gives one sine/cosine word out, in order, so expected
// results wait in a FIFO and each output word is checked against the oldest.
module testbench;

    localparam int     LATENCY      = 10;
    localparam int     N_RANDOM     = 1750;
    localparam int     IDLE_LIMIT   = 2000;    // cycles without any handshake
    localparam int     QTR_TURN_Q24 = 26353589; // pi/2 in Q8.24
    localparam longint ONE_Q30      = 64'sd1073741824;
    localparam longint QTR_SCALE    = 64'sd2734261102; // 2/pi times 2^32

    // Fifth-level odd minimax set, Q2.30, highest power of x^2 first
    localparam longint LVL5_COEF [5] = '{
        64'sd161727, -64'sd5016330, 64'sd85564564, -64'sd693597806, 64'sd1686629669
    };

    typedef struct {
        scp_pkg::t_q230 sine;
        scp_pkg::t_q230 cosine;
    } t_sincos;

    // One row of the directed part; typed rows carry their own expected word
    typedef struct packed {
        scp_pkg::t_angle angle;
        logic            typed;
        scp_pkg::t_q230  sine;
        scp_pkg::t_q230  cosine;
    } t_dir_row;

    localparam int N_DIR = 18;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{32'sh0000_0000, 1'b1, 32'sh0000_0000, 32'sh4000_0000}, // zero: exact 0 and 1.0
        '{32'sh0000_0001, 1'b0, '0, '0},                         // smallest positive
        '{32'shFFFF_FFFF, 1'b0, '0, '0},                         // smallest negative
        '{32'sh7FFF_FFFF, 1'b0, '0, '0},                         // most positive angle
        '{32'sh8000_0000, 1'b0, '0, '0},                         // most negative angle
        '{32'sh0192_1FB5, 1'b0, '0, '0},                         // pi/2
        '{32'sh0192_1FB4, 1'b0, '0, '0},                         // just under pi/2
        '{32'sh0192_1FB6, 1'b0, '0, '0},                         // just over pi/2
        '{-32'sh0192_1FB5, 1'b0, '0, '0},                        // -pi/2
        '{32'sh0324_3F6B, 1'b0, '0, '0},                         // pi
        '{-32'sh0324_3F6B, 1'b0, '0, '0},                        // -pi
        '{32'sh04B6_5F20, 1'b0, '0, '0},                         // 3pi/2
        '{32'sh0648_7ED5, 1'b0, '0, '0},                         // 2pi
        '{32'sh5555_5555, 1'b0, '0, '0},
        '{32'shAAAA_AAAA, 1'b0, '0, '0},
        '{32'sh00FF_FFFF, 1'b0, '0, '0},                         // just under 1 rad
        '{32'shFF00_0000, 1'b0, '0, '0},                         // -1 rad
        '{32'sh7D8B_2A50, 1'b0, '0, '0}                          // just under 80 quarter-turns
    };

    logic i_clk;
    logic i_rst_n;

    scp_in_if  in_if ();
    scp_out_if out_if ();

    // Typed flag and expectation that go with the word now on the input
    logic           cur_typed;
    scp_pkg::t_q230 cur_sine;
    scp_pkg::t_q230 cur_cosine;
    logic           calm;          // no idling on either side while set
    int             stall_left;
    int             idle_cycles;
    int             error_count;
    t_sincos        pending_sc [$];

    sine_cosine_poly_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------- predictor

    // Round a Q.60 product back to Q.30, ties toward plus infinity
    function automatic longint round_q30(input longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Fold quarter-turns u (Q.30) into a triangle wave, then run the odd
    // polynomial through Horner's rule in x^2 and saturate to +-1.0
    function automatic longint fold_poly(input longint u);
        longint turns;
        longint odd_turn;
        longint gap;
        longint tri_v;
        longint sq;
        longint acc;
        longint res;
        turns    = u / ONE_Q30;   // truncate toward zero
        odd_turn = turns[0] ? turns : turns + 1;
        gap      = u - odd_turn * ONE_Q30;
        tri_v    = (gap < 0) ? -gap : gap;
        // bit 1 of the quarter-turn count picks the slope
        tri_v    = turns[1] ? tri_v - ONE_Q30 : ONE_Q30 - tri_v;
        sq       = round_q30(tri_v * tri_v);
        acc      = LVL5_COEF[0];
        for (int k = 1; k < 5; k++)
            acc = LVL5_COEF[k] + round_q30(acc * sq);
        res = round_q30(tri_v * acc);
        if (res > ONE_Q30)
            res = ONE_Q30;
        if (res < -ONE_Q30)
            res = -ONE_Q30;
        return res;
    endfunction

    function automatic t_sincos predict_sincos(input scp_pkg::t_angle angle);
        longint  quarters;
        t_sincos r;
        // scale by 2/pi: Q8.24 times Q.32 down to Q.30 quarter-turns
        quarters = (longint'(angle) * QTR_SCALE + (64'sd1 <<< 25)) >>> 26;
        r.sine   = scp_pkg::t_q230'(fold_poly(quarters));
        // cosine leads by a quarter-turn
        r.cosine = scp_pkg::t_q230'(fold_poly(quarters + ONE_Q30));
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Sample both channels at the rising edge: queue the expectation of each
    // accepted angle word, then check each accepted result word in order.
    always @(posedge i_clk) begin
        t_sincos want;
        t_sincos got;
        logic    moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
                moved = 1'b1;
                if (cur_typed) begin
                    want.sine   = cur_sine;
                    want.cosine = cur_cosine;
                end else begin
                    want = predict_sincos(in_if.angle);
                end
                pending_sc.push_back(want);
            end
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                moved      = 1'b1;
                got.sine   = out_if.sine;
                got.cosine = out_if.cosine;
                if (pending_sc.size() == 0) begin
                    report_mismatch($sformatf("result word with no angle pending: sin %h cos %h",
                                              got.sine, got.cosine));
                end else begin
                    want = pending_sc.pop_front();
                    if (got.sine !== want.sine)
                        report_mismatch($sformatf("sine %h, expected %h",
                                                  got.sine, want.sine));
                    if (got.cosine !== want.cosine)
                        report_mismatch($sformatf("cosine %h, expected %h",
                                                  got.cosine, want.cosine));
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // ---------------------------------------------------------------- stimulus

    // Hold ready low in bursts of random length, none while calm
    always @(negedge i_clk) begin
        if (calm) begin
            out_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(0, 11);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Draw an angle: full range most often, plus words near quarter-turn
    // boundaries where the fold and the saturation act, small angles, the
    // ends of the range and powers of two.
    function automatic scp_pkg::t_angle random_angle();
        int pick;
        int k;
        int off;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return scp_pkg::t_angle'($urandom);
        if (pick < 7) begin
            k   = $urandom_range(0, 162);
            k   = k - 81;
            off = $urandom_range(0, 4000);
            off = off - 2000;
            return scp_pkg::t_angle'(k * QTR_TURN_Q24 + off);
        end
        if (pick < 9) begin
            off = $urandom_range(0, 33554431);
            return scp_pkg::t_angle'(off - 16777216);
        end
        case ($urandom_range(0, 2))
            0:       return scp_pkg::t_angle'(32'h7FFF_FFFF - $urandom_range(0, 255));
            1:       return scp_pkg::t_angle'(32'h8000_0000 + $urandom_range(0, 255));
            default: return scp_pkg::t_angle'(32'h1 << $urandom_range(0, 31));
        endcase
    endfunction

    // Present one angle word from a falling edge and hold it until taken;
    // return at the falling edge after the handshake.
    task automatic send_angle(input scp_pkg::t_angle angle, input logic typed,
                              input t_sincos typed_sc);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.angle <= angle;
        cur_typed   <= typed;
        cur_sine    <= typed_sc.sine;
        cur_cosine  <= typed_sc.cosine;
        do
            @(posedge i_clk);
        while (in_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Drop the run once nothing has moved for too long
    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(negedge i_clk);
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_sincos row_sc;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.angle  = '0;
        out_if.ready = 1'b0;
        cur_typed    = 1'b0;
        cur_sine     = '0;
        cur_cosine   = '0;
        calm         = 1'b0;
        stall_left   = 0;
        idle_cycles  = 0;
        error_count  = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows first
        for (int r = 0; r < N_DIR; r++) begin
            row_sc.sine   = DIR_ROWS[r].sine;
            row_sc.cosine = DIR_ROWS[r].cosine;
            send_angle(DIR_ROWS[r].angle, DIR_ROWS[r].typed, row_sc);
        end

        // random words; a quiet stretch in the middle and at the end
        row_sc.sine   = '0;
        row_sc.cosine = '0;
        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 700 && n < 850) || n >= N_RANDOM - 200;
            send_angle(random_angle(), 1'b0, row_sc);
        end
        in_if.valid <= 1'b0;

        // drain, then give stray words time to show up
        while (pending_sc.size() != 0)
            @(negedge i_clk);
        repeat (2 * LATENCY) @(negedge i_clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
